// File: rtl/orle_pkg.sv
package orle_pkg;

  localparam int CAPACITY   = 16;
  localparam int NAME_BYTES = 8;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int REC_W = 96;

  localparam logic [63:0] NAME_MASK = 64'((128'(1) << (NAME_BYTES * 8)) - 128'(1));

  localparam logic [1:0] REQ_APPEND   = 2'd0;
  localparam logic [1:0] REQ_DELETE   = 2'd1;
  localparam logic [1:0] REQ_POP_TAIL = 2'd2;
  localparam logic [1:0] REQ_POP_HEAD = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               match_by_name;
    logic signed [31:0] item_code;
    logic [63:0]        item_name;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_code;
    logic [63:0]        removed_name;
    logic [4:0]         entry_count;
  } result_t;

  typedef struct packed {
    logic signed [31:0] code;
    logic [63:0]        name;
  } record_t;

  typedef struct packed {
    logic        force_hit;
    logic        by_name;
    logic [31:0] code;
    logic [63:0] name;
  } match_key_t;

endpackage

// File: rtl/orle_ram.sv
module orle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/orle_match.sv
module orle_match (
  input  orle_pkg::match_key_t key,
  input  orle_pkg::record_t    entry,
  output logic                 hit
);

  logic code_eq;
  logic name_eq;

  assign code_eq = (entry.code == key.code);
  assign name_eq = (entry.name == key.name);
  assign hit     = key.force_hit | (key.by_name ? name_eq : code_eq);

endmodule

// File: rtl/ordered_record_list_engine.sv
// Channel   Direction  Signals                Transfer when
// request   in         start, request, busy   start high and busy low at a clock edge
// result    out        done, result           done high; one cycle, never held off
//
// Append, and any removal from an empty list, gives its result on the cycle after it
// is taken, and busy stays low throughout.
// Delete and head pop keep busy high while the single RAM read port walks one entry a
// cycle to find the record, then moves later entries down one a cycle.
// Tail pop passes through S_TAIL, where the registered RAM read gives the last entry.
// Reset empties the list at once; the stores need no clearing.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module ordered_record_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  orle_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output orle_pkg::result_t  result
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_TAIL   = 4'b1000
  } state_t;

  localparam logic [orle_pkg::CNT_W-1:0] CNT_ONE  = orle_pkg::CNT_W'(1);
  localparam logic [orle_pkg::CNT_W-1:0] CNT_FULL = orle_pkg::CNT_W'(orle_pkg::CAPACITY);

  state_t                      state;
  logic [orle_pkg::CNT_W-1:0]  count;
  logic [orle_pkg::CNT_W-1:0]  ptr;
  orle_pkg::request_t          key;
  orle_pkg::record_t           removed;

  logic                        wr_en;
  logic [orle_pkg::IDX_W-1:0]  wr_addr;
  logic [orle_pkg::REC_W-1:0]  wr_data;
  logic [orle_pkg::IDX_W-1:0]  rd_addr;
  logic [orle_pkg::REC_W-1:0]  rd_data;
  orle_pkg::record_t           rd_rec;
  orle_pkg::record_t           new_rec;
  orle_pkg::match_key_t        mkey;
  logic                        hit;
  logic [orle_pkg::CNT_W-1:0]  ptr_inc;
  logic [orle_pkg::CNT_W-1:0]  count_dec;

  assign busy      = (state != S_IDLE);
  assign rd_rec    = orle_pkg::record_t'(rd_data);
  assign ptr_inc   = ptr + CNT_ONE;
  assign count_dec = count - CNT_ONE;

  assign new_rec.code = request.item_code;
  assign new_rec.name = request.item_name & orle_pkg::NAME_MASK;

  assign mkey.force_hit = (key.req_type == orle_pkg::REQ_POP_HEAD);
  assign mkey.by_name   = key.match_by_name;
  assign mkey.code      = key.item_code;
  assign mkey.name      = key.item_name;

  orle_match u_match (
    .key   (mkey),
    .entry (rd_rec),
    .hit   (hit)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[orle_pkg::IDX_W-1:0];
    wr_data = new_rec;
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        if (start && request.req_type == orle_pkg::REQ_APPEND && count != CNT_FULL) begin
          wr_en = 1'b1;
        end
        if (request.req_type == orle_pkg::REQ_POP_TAIL) begin
          rd_addr = count_dec[orle_pkg::IDX_W-1:0];
        end
      end
      S_SEARCH: begin
        rd_addr = ptr_inc[orle_pkg::IDX_W-1:0];
      end
      S_SHIFT: begin
        rd_addr = ptr_inc[orle_pkg::IDX_W-1:0] + orle_pkg::IDX_W'(1);
        wr_addr = ptr[orle_pkg::IDX_W-1:0];
        wr_data = rd_data;
        wr_en   = (ptr_inc < count);
      end
      S_TAIL: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  orle_ram #(
    .WIDTH (orle_pkg::REC_W),
    .DEPTH (orle_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key <= {request.req_type, request.match_by_name, request.item_code, new_rec.name};
            ptr                <= '0;
            result.removed_code <= '0;
            result.removed_name <= '0;
            if (request.req_type == orle_pkg::REQ_APPEND) begin
              done <= 1'b1;
              if (count == CNT_FULL) begin
                result.status      <= orle_pkg::ST_FULL;
                result.entry_count <= 5'(count);
              end else begin
                count              <= count + CNT_ONE;
                result.status      <= orle_pkg::ST_DONE;
                result.entry_count <= 5'(count + CNT_ONE);
              end
            end else if (count == '0) begin
              done               <= 1'b1;
              result.status      <= orle_pkg::ST_EMPTY;
              result.entry_count <= 5'(count);
            end else if (request.req_type == orle_pkg::REQ_POP_TAIL) begin
              state <= S_TAIL;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            removed <= rd_rec;
            state   <= S_SHIFT;
          end else if (ptr == count_dec) begin
            done               <= 1'b1;
            result.status      <= orle_pkg::ST_NOT_FOUND;
            result.entry_count <= 5'(count);
            state              <= S_IDLE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_SHIFT: begin
          if (ptr_inc < count) begin
            ptr <= ptr_inc;
          end else begin
            done                <= 1'b1;
            result.status       <= orle_pkg::ST_DONE;
            result.removed_code <= removed.code;
            result.removed_name <= removed.name;
            result.entry_count  <= 5'(count_dec);
            count               <= count_dec;
            state               <= S_IDLE;
          end
        end
        S_TAIL: begin
          done                <= 1'b1;
          result.status       <= orle_pkg::ST_DONE;
          result.removed_code <= rd_rec.code;
          result.removed_name <= rd_rec.name;
          result.entry_count  <= 5'(count_dec);
          count               <= count_dec;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/ordered_record_list_engine_test.sv
`timescale 1ns / 100ps

module ordered_record_list_engine_test;
  import orle_pkg::*;

  localparam int RANDOM_ITEMS  = 600;
  localparam int CYCLE_LIMIT   = 250000;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

  typedef struct {
    request_t req;
    bit       pinned;
    result_t  want;
  } script_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     done;
  result_t  result;

  logic signed [31:0] held_code [CAPACITY];
  logic [63:0]        held_name [CAPACITY];
  int                 held_count = 0;

  result_t     pending_results[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          requests_sent = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          status_seen[4] = '{0, 0, 0, 0};

  ordered_record_list_engine i_dut (
    .clk,
    .rst,
    .start,
    .request,
    .busy,
    .done,
    .result
  );

  always #5 clk = ~clk;

  function automatic result_t predict_list_result(request_t req);
    result_t     res;
    logic [63:0] key_name;
    int          pos;
    int          i;
    res = '0;
    res.status = ST_DONE;
    key_name = req.item_name & NAME_MASK;
    pos = -1;
    if (req.req_type == REQ_APPEND) begin
      if (held_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        held_code[held_count] = req.item_code;
        held_name[held_count] = key_name;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else if (req.req_type == REQ_POP_TAIL) begin
      pos = held_count - 1;
    end else if (req.req_type == REQ_POP_HEAD) begin
      pos = 0;
    end else begin
      for (i = 0; i < held_count && pos < 0; i++) begin
        if (req.match_by_name ? (held_name[i] == key_name) : (held_code[i] == req.item_code))
          pos = i;
      end
      if (pos < 0)
        res.status = ST_NOT_FOUND;
    end
    if (pos >= 0) begin
      res.removed_code = held_code[pos];
      res.removed_name = held_name[pos];
      for (i = pos; i + 1 < held_count; i++) begin
        held_code[i] = held_code[i + 1];
        held_name[i] = held_name[i + 1];
      end
      held_count--;
    end
    res.entry_count = 5'(held_count);
    return res;
  endfunction

  function automatic script_row_t row(logic [1:0] kind, logic by_name, logic [31:0] code,
                                      logic [63:0] name, bit pinned, logic [1:0] st,
                                      logic [31:0] rcode, logic [63:0] rname, logic [4:0] cnt);
    script_row_t r;
    r.req.req_type      = kind;
    r.req.match_by_name = by_name;
    r.req.item_code     = code;
    r.req.item_name     = name;
    r.pinned            = pinned;
    r.want.status       = st;
    r.want.removed_code = rcode;
    r.want.removed_name = rname;
    r.want.entry_count  = cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic send_request(request_t req, bit pinned, result_t want);
    int      gap;
    result_t predicted;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = 0;
      burst_left = $urandom_range(5, 30);
    end else begin
      gap = $urandom_range(0, 10);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    predicted = predict_list_result(req);
    pending_results.push_back(pinned ? want : predicted);
    requests_sent++;
  endtask

  always @(posedge clk) begin : result_check
    result_t oldest;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("ordered_record_list_engine_test failed");
      $finish;
    end else if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding, status", result.status, '0);
      end else begin
        oldest = pending_results.pop_front();
        results_seen++;
        status_seen[result.status]++;
        if (result.status !== oldest.status)
          report_mismatch("status", result.status, oldest.status);
        if (result.removed_code !== oldest.removed_code)
          report_mismatch("removed_code", result.removed_code, oldest.removed_code);
        if (result.removed_name !== oldest.removed_name)
          report_mismatch("removed_name", result.removed_name, oldest.removed_name);
        if (result.entry_count !== oldest.entry_count)
          report_mismatch("entry_count", result.entry_count, oldest.entry_count);
      end
    end
  end

  initial begin
    request_t    req;
    logic [31:0] code;
    logic [63:0] name;
    int          k;
    int          pick;
    bit          draining;

    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;

    script.push_back(row(REQ_POP_TAIL, 1'b0, '0, '0, 1'b1, ST_EMPTY, '0, '0, 5'd0));
    script.push_back(row(REQ_POP_HEAD, 1'b1, '1, '1, 1'b1, ST_EMPTY, '0, '0, 5'd0));
    script.push_back(row(REQ_DELETE, 1'b1, '1, '1, 1'b1, ST_EMPTY, '0, '0, 5'd0));
    for (k = 0; k < CAPACITY; k++) begin
      code = $urandom | 32'd1;
      name = {$urandom, $urandom};
      if (k == 0) begin
        code = 32'h8000_0000;
        name = '0;
      end
      if (k == 1) begin
        code = 32'h7fff_ffff;
        name = '1;
      end
      script.push_back(row(REQ_APPEND, 1'(k), code, name, 1'b1, ST_DONE, '0, '0, 5'(k + 1)));
    end
    script.push_back(row(REQ_APPEND, 1'b0, 32'd1, 64'd1, 1'b1, ST_FULL, '0, '0, 5'd16));
    // The name here matches a held record, but only the code is compared.
    script.push_back(row(REQ_DELETE, 1'b0, 32'h2468_ace0, '1, 1'b1, ST_NOT_FOUND, '0, '0,
                         5'd16));
    script.push_back(row(REQ_DELETE, 1'b1, 32'h8000_0000, '1, 1'b1, ST_DONE, 32'h7fff_ffff,
                         '1, 5'd15));
    script.push_back(row(REQ_DELETE, 1'b0, 32'h8000_0000, '1, 1'b0, ST_DONE, '0, '0, '0));
    script.push_back(row(REQ_POP_TAIL, 1'b1, '0, '0, 1'b0, ST_DONE, '0, '0, '0));
    script.push_back(row(REQ_POP_HEAD, 1'b0, '1, '0, 1'b0, ST_DONE, '0, '0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k])
      send_request(script[k].req, script[k].pinned, script[k].want);

    // Fill and drain in turn, so that full and empty lists come up again and again.
    draining = 1'b0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (held_count == CAPACITY)
        draining = 1'b1;
      else if (held_count == 0)
        draining = 1'b0;
      req.match_by_name = $urandom_range(0, 1);
      req.item_code = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) - 32'd4
                                                  : $urandom;
      req.item_name = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 7))
                                                  : {$urandom, $urandom};
      if ($urandom_range(0, 99) < (draining ? 25 : 70)) begin
        req.req_type = REQ_APPEND;
      end else begin
        case ($urandom_range(0, 3))
          0, 1: req.req_type = REQ_DELETE;
          2: req.req_type = REQ_POP_TAIL;
          default: req.req_type = REQ_POP_HEAD;
        endcase
        if (req.req_type == REQ_DELETE && held_count > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, held_count - 1);
          if (req.match_by_name)
            req.item_name = held_name[pick];
          else
            req.item_code = held_code[pick];
        end
      end
      send_request(req, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests, %0d of them from the directed table; checked %0d results.",
             requests_sent, script.size(), results_seen);
    $display("Statuses seen: %0d done, %0d not found, %0d full, %0d empty.",
             status_seen[ST_DONE], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("ordered_record_list_engine_test passed");
    end else begin
      $display("ordered_record_list_engine_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/orle_pkg.sv
rtl/orle_ram.sv
rtl/orle_match.sv
rtl/ordered_record_list_engine.sv
tb/ordered_record_list_engine_test.sv
